// File: hw/rtl/srti_pkg.sv
// Shared types and constants for the sorted record table.
package srti_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = 5;
	localparam int CNT_W    = 6;
	localparam int DATE_W   = 23;
	localparam int KEY_W    = 64 + 48 + 24 + DATE_W;

	// Result status codes
	localparam logic [2:0] ST_MERGED   = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_READ_OK  = 3'd3;
	localparam logic [2:0] ST_BEYOND   = 3'd4;

	// Cell operation codes
	localparam logic [1:0] OP_HOLD  = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_SHIFT = 2'd2;
	localparam logic [1:0] OP_ADD   = 2'd3;

	typedef struct packed {
		logic        func;
		logic [63:0] name_high;
		logic [47:0] name_low;
		logic [23:0] price;
		logic [31:0] amount;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [4:0]  index;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  position;
		logic [63:0] out_name_high;
		logic [47:0] out_name_low;
		logic [23:0] out_price;
		logic [31:0] out_amount;
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [13:0] out_year;
		logic [5:0]  entry_count;
	} out_t;

	// One stored record; date is year, month, day so packed order is date order
	typedef struct packed {
		logic [63:0]       name_high;
		logic [47:0]       name_low;
		logic [23:0]       price;
		logic [DATE_W-1:0] date;
		logic [31:0]       amount;
	} entry_t;

	typedef struct packed {
		logic [1:0] op;
	} cell_ctl_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cell_flag_t;

endpackage

// File: hw/rtl/srti_cell.sv
// One table cell: holds a record, compares it with the key, loads, shifts or merges amounts.
module srti_cell (
	input  logic              clk,
	input  srti_pkg::entry_t  key,
	input  srti_pkg::entry_t  nbr,
	input  srti_pkg::cell_ctl_t ctl,
	output srti_pkg::entry_t  entry,
	output srti_pkg::cell_flag_t flag
);
	import srti_pkg::*;

	entry_t       entry_q;
	logic [KEY_W-1:0] own_key;
	logic [KEY_W-1:0] in_key;
	logic [32:0]  sum;

	// Compare stored key with the broadcast key
	assign own_key = {entry_q.name_high, entry_q.name_low, entry_q.price, entry_q.date};
	assign in_key  = {key.name_high, key.name_low, key.price, key.date};
	assign flag.lt = own_key < in_key;
	assign flag.eq = own_key == in_key;

	// Saturating merge of amounts
	assign sum = {1'b0, entry_q.amount} + {1'b0, key.amount};

	// Record update
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD:  entry_q <= key;
			OP_SHIFT: entry_q <= nbr;
			OP_ADD:   entry_q.amount <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			default:  entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;

endmodule

// File: hw/rtl/sorted_record_table_insert.sv
// Sorted record table: a row of compare-and-shift cells with merge or insert.
// Add items pass through the compare, update and output states before the result is valid;
// reads go straight to the output state. One item at a time: the next item is taken the
// cycle after the result is taken.
// Reset (arst_n low): entry count zero, no result pending; cell contents undefined.
module sorted_record_table_insert (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  srti_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output srti_pkg::out_t  out_data
);
	import srti_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]       state_q;
	in_t              req_q;
	entry_t           key;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] pos_q;
	logic [2:0]       status_q;
	out_t             out_q;
	out_t             out_next;
	logic             out_valid_q;

	entry_t     cells   [CAPACITY];
	cell_flag_t flags   [CAPACITY];
	cell_ctl_t  ctls    [CAPACITY];
	logic [CAPACITY-1:0] lt_s1, eq_s1;
	logic [CAPACITY-1:0] below, prev_below, hit, ins, shift;
	logic                merge, full;
	logic [IDX_W-1:0]    hit_pos, ins_pos;

	assign key = '{name_high: req_q.name_high, name_low: req_q.name_low, price: req_q.price,
		date: {req_q.year, req_q.month, req_q.day}, amount: req_q.amount};

	// Cell row; each cell takes its lower neighbor's record on a shift
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		srti_cell u_cell (
			.clk  (clk),
			.key  (key),
			.nbr  ((i == 0) ? key : cells[(i == 0) ? 0 : i - 1]),
			.ctl  (ctls[i]),
			.entry(cells[i]),
			.flag (flags[i])
		);

		// Placement decode from registered compare flags
		always_comb begin
			below[i]      = lt_s1[i] && (CNT_W'(i) < count_q);
			prev_below[i] = (i == 0) ? 1'b1 : below[(i == 0) ? 0 : i - 1];
			hit[i]        = eq_s1[i] && (CNT_W'(i) < count_q) && prev_below[i];
			ins[i]        = !below[i] && prev_below[i] && (CNT_W'(i) <= count_q);
			shift[i]      = !below[i] && !prev_below[i] && (CNT_W'(i) <= count_q);
		end

		always_comb begin
			ctls[i].op = OP_HOLD;
			if (state_q == S_UPD) begin
				if (merge) begin
					if (hit[i]) ctls[i].op = OP_ADD;
				end else if (!full) begin
					if (ins[i]) ctls[i].op = OP_LOAD;
					else if (shift[i]) ctls[i].op = OP_SHIFT;
				end
			end
		end
	end

	assign merge = |hit;
	assign full  = count_q == CNT_W'(CAPACITY);

	// One-hot to index encode
	always_comb begin
		hit_pos = '0;
		ins_pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit[i]) hit_pos = hit_pos | IDX_W'(i);
			if (ins[i]) ins_pos = ins_pos | IDX_W'(i);
		end
	end

	// Compare flag stage
	always_ff @(posedge clk) begin
		if (state_q == S_CMP) begin
			for (int i = 0; i < CAPACITY; i++) begin
				lt_s1[i] <= flags[i].lt;
				eq_s1[i] <= flags[i].eq;
			end
		end
	end

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;

	// Sequencer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) state_q <= in_data.func ? S_OUT : S_CMP;
				end
				S_CMP: state_q <= S_UPD;
				S_UPD: begin
					if (!merge && !full) count_q <= count_q + CNT_W'(1);
					state_q <= S_OUT;
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request, position and status
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_ready) begin
			req_q <= in_data;
			pos_q <= in_data.index;
			status_q <= ({1'b0, in_data.index} < count_q) ? ST_READ_OK : ST_BEYOND;
		end
		if (state_q == S_UPD) begin
			if (merge) begin
				pos_q    <= hit_pos;
				status_q <= ST_MERGED;
			end else if (full) begin
				pos_q    <= '0;
				status_q <= ST_FULL;
			end else begin
				pos_q    <= ins_pos;
				status_q <= ST_INSERTED;
			end
		end
	end

	// Result fields; full and beyond-count results carry no entry
	always_comb begin
		out_next = '0;
		out_next.status      = status_q;
		out_next.entry_count = count_q;
		if (status_q != ST_FULL && status_q != ST_BEYOND) begin
			out_next.position      = pos_q;
			out_next.out_name_high = cells[pos_q].name_high;
			out_next.out_name_low  = cells[pos_q].name_low;
			out_next.out_price     = cells[pos_q].price;
			out_next.out_amount    = cells[pos_q].amount;
			out_next.out_day       = cells[pos_q].date[4:0];
			out_next.out_month     = cells[pos_q].date[8:5];
			out_next.out_year      = cells[pos_q].date[22:9];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == S_OUT) out_q <= out_next;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY)) else $error("entry count above capacity");
	a_hit_single: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> $onehot0(hit)) else $error("more than one merge cell");
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && !merge && !full) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow count");
	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == S_IDLE) else $error("result pending while busy");

endmodule

// File: sim/tb_top.sv
// Testbench for the sorted record table: queued driver, clocked monitor, table predictor.
module tb_top;
	import srti_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	sorted_record_table_insert u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// Predictor state: shadow copy of the sorted table
	logic [63:0] tbl_nh [CAPACITY];
	logic [47:0] tbl_nl [CAPACITY];
	logic [23:0] tbl_pr [CAPACITY];
	logic [31:0] tbl_am [CAPACITY];
	logic [22:0] tbl_dt [CAPACITY];
	int          tbl_cnt;

	in_t  pending_items[$];
	out_t expected_results[$];
	int   mismatches;
	int   sender_idle_pct;
	int   recv_stall_pct;

	// -1, 0, 1 as table entry is below, equal to, above the key
	function automatic int compare_entry(int p, in_t it);
		logic [22:0] dt;
		dt = {it.year, it.month, it.day};
		if (tbl_nh[p] != it.name_high) return tbl_nh[p] < it.name_high ? -1 : 1;
		if (tbl_nl[p] != it.name_low) return tbl_nl[p] < it.name_low ? -1 : 1;
		if (tbl_pr[p] != it.price) return tbl_pr[p] < it.price ? -1 : 1;
		if (tbl_dt[p] != dt) return tbl_dt[p] < dt ? -1 : 1;
		return 0;
	endfunction

	function automatic out_t entry_result(logic [2:0] st, int p);
		out_t r;
		r = '0;
		r.status = st;
		r.position = p[4:0];
		r.out_name_high = tbl_nh[p];
		r.out_name_low = tbl_nl[p];
		r.out_price = tbl_pr[p];
		r.out_amount = tbl_am[p];
		r.out_day = tbl_dt[p][4:0];
		r.out_month = tbl_dt[p][8:5];
		r.out_year = tbl_dt[p][22:9];
		r.entry_count = tbl_cnt[5:0];
		return r;
	endfunction

	// Apply one accepted item to the shadow table and return its result
	function automatic out_t table_step(in_t it);
		out_t r;
		int lo, hi, mid;
		logic [32:0] sum;
		r = '0;
		if (it.func) begin
			if (int'(it.index) < tbl_cnt) return entry_result(ST_READ_OK, int'(it.index));
			r.status = ST_BEYOND;
			r.entry_count = tbl_cnt[5:0];
			return r;
		end
		lo = 0;
		hi = tbl_cnt;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (compare_entry(mid, it) < 0) lo = mid + 1;
			else hi = mid;
		end
		if (lo < tbl_cnt && compare_entry(lo, it) == 0) begin
			sum = {1'b0, tbl_am[lo]} + {1'b0, it.amount};
			tbl_am[lo] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			return entry_result(ST_MERGED, lo);
		end
		if (tbl_cnt >= CAPACITY) begin
			r.status = ST_FULL;
			r.entry_count = tbl_cnt[5:0];
			return r;
		end
		for (int i = tbl_cnt; i > lo; i--) begin
			tbl_nh[i] = tbl_nh[i-1];
			tbl_nl[i] = tbl_nl[i-1];
			tbl_pr[i] = tbl_pr[i-1];
			tbl_am[i] = tbl_am[i-1];
			tbl_dt[i] = tbl_dt[i-1];
		end
		tbl_nh[lo] = it.name_high;
		tbl_nl[lo] = it.name_low;
		tbl_pr[lo] = it.price;
		tbl_am[lo] = it.amount;
		tbl_dt[lo] = {it.year, it.month, it.day};
		tbl_cnt++;
		return entry_result(ST_INSERTED, lo);
	endfunction

	// Small name pools so that merges and neighbors are frequent
	function automatic in_t make_add(int pool);
		in_t it;
		it = '0;
		it.func = 1'b0;
		it.name_high = (pool == 0) ? {$urandom, $urandom} : 64'($urandom_range(3)) << 56;
		it.name_low = (pool == 0) ? {16'($urandom), $urandom} : 48'($urandom_range(2));
		it.price = (pool == 0) ? 24'($urandom) : 24'($urandom_range(2));
		it.amount = ($urandom_range(7) == 0) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom;
		it.day = (pool == 0) ? 5'($urandom_range(31, 1)) : 5'($urandom_range(2, 1));
		it.month = (pool == 0) ? 4'($urandom_range(12, 1)) : 4'($urandom_range(2, 1));
		it.year = (pool == 0) ? 14'($urandom_range(9999)) : 14'($urandom_range(2001, 2000));
		it.index = 5'($urandom);
		return it;
	endfunction

	function automatic in_t make_read(int idx);
		in_t it;
		it = make_add(0);
		it.func = 1'b1;
		it.index = idx[4:0];
		return it;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: holds each item until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Predict on acceptance
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			expected_results.push_back(table_step(in_data));
	end

	// Receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: compare against the oldest expectation
	always @(posedge clk) begin
		out_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", out_data);
			end else begin
				exp_r = expected_results.pop_front();
				if (out_data !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h got %h", exp_r, out_data);
				end
			end
		end
	end

	// Stimulus, phases and end of run
	initial begin
		in_t it;
		tbl_cnt = 0;
		mismatches = 0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty reads, extremes, merges, saturation, full table
		pending_items.push_back(make_read(0));
		pending_items.push_back(make_read(31));
		it = '1;
		it.func = 1'b0;
		it.day = 5'd31; it.month = 4'd12; it.year = 14'd9999;
		pending_items.push_back(it);
		pending_items.push_back(it);
		it = '0;
		it.day = 5'd1; it.month = 4'd1;
		pending_items.push_back(it);
		it.amount = 32'hFFFF_FFFF;
		pending_items.push_back(it);
		pending_items.push_back(it);
		pending_items.push_back(make_read(0));
		pending_items.push_back(make_read(1));
		pending_items.push_back(make_read(2));
		for (int i = 0; i < 31; i++) pending_items.push_back(make_add(0));
		pending_items.push_back(make_add(0));
		pending_items.push_back(make_read(31));
		it = '1;
		it.func = 1'b0;
		it.day = 5'd31; it.month = 4'd12; it.year = 14'd9999;
		pending_items.push_back(it);

		// Random phases; table refilled from empty is impossible, so reads and
		// merges dominate once full: use a small pool on an earlier reset-free mix
		for (int ph = 0; ph < 4; ph++) begin
			wait (pending_items.size() == 0);
			sender_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 72 : 38) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 72 : 38) : 0;
			for (int n = 0; n < 400; n++) begin
				case ($urandom_range(9))
					0, 1, 2: pending_items.push_back(make_read($urandom_range(31)));
					3, 4: pending_items.push_back(make_add(0));
					default: pending_items.push_back(make_add(1));
				endcase
			end
		end
		wait (pending_items.size() == 0 && expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Timeout
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/srti_pkg.sv
hw/rtl/srti_cell.sv
hw/rtl/sorted_record_table_insert.sv
sim/tb_top.sv
